FILE: sv/brs_pkg.sv
// brs_pkg: shared types and constants for the branch unit with return stack
// no dependencies; imported by brs_stack_cell, brs_return_stack and the top level
`default_nettype none

package brs_pkg;

   // line action codes
   typedef enum logic [2:0] {
      ACT_END        = 3'd0,
      ACT_CALL       = 3'd1,
      ACT_RET        = 3'd2,
      ACT_GO_ABS     = 3'd3,
      ACT_GO_REL     = 3'd4,
      ACT_SKIP_TRUE  = 3'd5,
      ACT_SKIP_FALSE = 3'd6,
      ACT_NONE       = 3'd7
   } action_type;

   // stack status codes reported with each result
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } stack_status_type;

   // configuration register indexes
   localparam logic [0:0] CSR_CODE_BASE   = 1'd0;
   localparam logic [0:0] CSR_LINE_LENGTH = 1'd1;

   localparam int AddrW = 32;

   // command from the branch logic to the stack
   typedef struct packed {
      logic push;
      logic pop;
   } stack_cmd_type;

   // flags from the stack to the branch logic
   typedef struct packed {
      logic full;
      logic empty;
   } stack_flags_type;

endpackage

`default_nettype wire

FILE: sv/brs_stack_cell.sv
// brs_stack_cell: one entry of the shifting return stack
// depends on brs_pkg
`default_nettype none

module brs_stack_cell (
   input  wire logic                       clock,
   input  wire brs_pkg::stack_cmd_type     cmd,
   input  wire logic [brs_pkg::AddrW-1:0]  above_data,
   input  wire logic [brs_pkg::AddrW-1:0]  below_data,
   output logic      [brs_pkg::AddrW-1:0]  cell_data
);
   import brs_pkg::*;

   logic [AddrW-1:0] data_ff;
   logic [AddrW-1:0] data_in;

   // push takes the entry from above, pop takes the entry from below
   always_comb begin
      data_in = data_ff;
      if (cmd.push) begin
         data_in = above_data;
      end else if (cmd.pop) begin
         data_in = below_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

`default_nettype wire

FILE: sv/brs_return_stack.sv
// brs_return_stack: row of shifting cells plus a depth counter
// depends on brs_pkg and brs_stack_cell
`default_nettype none

module brs_return_stack #(
   parameter int RETURN_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire brs_pkg::stack_cmd_type     cmd,
   input  wire logic [brs_pkg::AddrW-1:0]  push_data,
   output logic      [brs_pkg::AddrW-1:0]  top_data,
   output brs_pkg::stack_flags_type        flags
);
   import brs_pkg::*;

   localparam int DepthW = $clog2(RETURN_DEPTH + 1);
   localparam logic [DepthW-1:0] DepthMax = DepthW'(RETURN_DEPTH);

   logic [AddrW-1:0]  cell_data [RETURN_DEPTH];
   logic [DepthW-1:0] depth_ff;
   logic [DepthW-1:0] depth_in;

   // chain of cells, entry zero is the top of stack
   for (genvar i = 0; i < RETURN_DEPTH; i++) begin : g_cell
      logic [AddrW-1:0] above;
      logic [AddrW-1:0] below;
      if (i == 0) begin : g_head
         assign above = push_data;
      end else begin : g_mid
         assign above = cell_data[i-1];
      end
      if (i == RETURN_DEPTH - 1) begin : g_tail
         assign below = cell_data[i];
      end else begin : g_next
         assign below = cell_data[i+1];
      end
      brs_stack_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .above_data (above),
         .below_data (below),
         .cell_data  (cell_data[i])
      );
   end

   // occupancy counter
   always_comb begin
      depth_in = depth_ff;
      if (cmd.push) begin
         depth_in = depth_ff + DepthW'(1);
      end else if (cmd.pop) begin
         depth_in = depth_ff - DepthW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign top_data    = cell_data[0];
   assign flags.full  = (depth_ff == DepthMax);
   assign flags.empty = (depth_ff == '0);

   // checks
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop in the same cycle");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && flags.full) && !(cmd.pop && flags.empty))
      else $error("stack overflow or underflow");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthMax)
      else $error("stack depth out of range");

   a_push_top: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> top_data == $past(push_data))
      else $error("pushed address not on top of stack");

endmodule

`default_nettype wire

FILE: sv/branch_unit_with_return_stack_unit.sv
// branch_unit_with_return_stack_unit: control-flow unit of a line interpreter
// depends on brs_pkg and brs_return_stack
//
// Usage: one request transaction per program line on req_* carries the action,
// the already advanced address, the line operand and the condition value. One
// response transaction on rsp_* returns the next address, a stop flag and the
// stack status. Calls push the current address onto a return stack built as a
// row of shifting cells; returns pop it. code_base and line_length are written
// through csr_*, index 0 and 1; the user must write them only while the unit is
// idle, which the unit itself does not enforce. The response is registered.
// Throughput: one line per cycle while rsp_ready is high; the address is formed
// by one 9x17 multiply and one 32-bit add; the stack top is always in the first cell.
// Reset: empty stack, code_base 0, line_length 1, no response pending.
// Stall: while rsp_ready is low with a response held, req_ready drops; a new
// request is taken in the same cycle the held response leaves.
`default_nettype none

module branch_unit_with_return_stack_unit #(
   parameter int RETURN_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // configuration
   input  wire logic                       csr_write,
   input  wire logic [0:0]                 csr_index,
   input  wire logic [brs_pkg::AddrW-1:0]  csr_data,
   // request
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [2:0]                 req_action,
   input  wire logic [brs_pkg::AddrW-1:0]  req_current_addr,
   input  wire logic [15:0]                req_line_operand,
   input  wire logic signed [31:0]         req_cond_value,
   // response
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [brs_pkg::AddrW-1:0]  rsp_next_addr,
   output logic                            rsp_run_stopped,
   output logic      [1:0]                 rsp_stack_status
);
   import brs_pkg::*;

   logic [AddrW-1:0]  code_base_ff;
   logic [7:0]        line_length_ff;
   logic              rsp_valid_ff;
   logic [AddrW-1:0]  next_addr_ff;
   logic [AddrW-1:0]  next_addr_in;
   logic              stopped_ff;
   logic              stopped_in;
   stack_status_type  status_ff;
   stack_status_type  status_in;

   logic              req_fire;
   action_type        action;
   stack_cmd_type     stack_cmd;
   stack_flags_type   stack_flags;
   logic [AddrW-1:0]  stack_top;
   logic              use_base;
   logic              use_sum;
   logic signed [16:0] mul_operand;
   logic signed [25:0] product;
   logic [AddrW-1:0]  offset;
   logic [AddrW-1:0]  sum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         code_base_ff   <= '0;
         line_length_ff <= 8'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CODE_BASE:   code_base_ff   <= csr_data;
            CSR_LINE_LENGTH: line_length_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign action    = action_type'(req_action);

   // action decode
   always_comb begin
      stack_cmd   = '0;
      use_base    = 1'b0;
      use_sum     = 1'b0;
      mul_operand = '0;
      stopped_in  = 1'b0;
      status_in   = STAT_OK;
      unique case (action)
         ACT_END: begin
            stopped_in = 1'b1;
         end
         ACT_CALL: begin
            if (stack_flags.full) begin
               status_in = STAT_FULL;
            end else begin
               stack_cmd.push = req_fire;
               use_base       = 1'b1;
               use_sum        = 1'b1;
               mul_operand    = $signed({1'b0, req_line_operand});
            end
         end
         ACT_RET: begin
            if (stack_flags.empty) begin
               status_in = STAT_EMPTY;
            end else begin
               stack_cmd.pop = req_fire;
            end
         end
         ACT_GO_ABS: begin
            use_base    = 1'b1;
            use_sum     = 1'b1;
            mul_operand = $signed({1'b0, req_line_operand});
         end
         ACT_GO_REL: begin
            use_sum     = 1'b1;
            mul_operand = $signed({req_line_operand[15], req_line_operand}) - 17'sd1;
         end
         ACT_SKIP_TRUE: begin
            use_sum     = 1'b1;
            mul_operand = (req_cond_value != '0) ? 17'sd1 : 17'sd0;
         end
         ACT_SKIP_FALSE: begin
            use_sum     = 1'b1;
            mul_operand = (req_cond_value == '0) ? 17'sd1 : 17'sd0;
         end
         ACT_NONE: begin
         end
         default: ;
      endcase
   end

   // stride multiply and address add
   assign product = $signed({1'b0, line_length_ff}) * mul_operand;
   assign offset  = {{(AddrW-26){product[25]}}, product};
   assign sum     = (use_base ? code_base_ff : req_current_addr) + offset;

   always_comb begin
      if (stack_cmd.pop) begin
         next_addr_in = stack_top;
      end else if (use_sum) begin
         next_addr_in = sum;
      end else begin
         next_addr_in = req_current_addr;
      end
   end

   brs_return_stack #(
      .RETURN_DEPTH (RETURN_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stack_cmd),
      .push_data (req_current_addr),
      .top_data  (stack_top),
      .flags     (stack_flags)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         next_addr_ff <= next_addr_in;
         stopped_ff   <= stopped_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_addr    = next_addr_ff;
   assign rsp_run_stopped  = stopped_ff;
   assign rsp_stack_status = status_ff;

   // checks
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(next_addr_ff))
      else $error("held response changed under stall");

   a_stop_only_end: assert property (@(posedge clock) disable iff (reset)
      req_fire && action != ACT_END |=> !stopped_ff)
      else $error("stop flag on a non-end action");

   a_stack_cmd_on_fire: assert property (@(posedge clock) disable iff (reset)
      (stack_cmd.push || stack_cmd.pop) |-> req_fire)
      else $error("stack moved without a transaction");

endmodule

`default_nettype wire
